// ----- rtl/core/aohl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aohl_pkg
// Shared types and constants for the alpha-over / hard light blend core.
// ----------------------------------------------------------------------------
package aohl_pkg;

  localparam int NumCh = 3;   // blue, green, red
  localparam int NumW  = 41;  // numerator / remainder width
  localparam int DenW  = 33;  // 65280 * alpha sum
  localparam int QuoW  = 8;

  localparam logic [15:0] AlphaFloor = 16'd196;
  localparam logic [8:0]  WeightFull = 9'd256;

  typedef enum logic [0:0] {
    CfgHlEnable = 1'b0,
    CfgHlWeight = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] bg_blue;
    logic [7:0] bg_green;
    logic [7:0] bg_red;
    logic [7:0] bg_alpha;
    logic [7:0] fg_blue;
    logic [7:0] fg_green;
    logic [7:0] fg_red;
    logic [7:0] fg_alpha;
  } aohl_in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
  } aohl_out_t;

  // State carried through the divider stages
  typedef struct packed {
    logic [NumCh-1:0][NumW-1:0] rem;
    logic [NumCh-1:0][QuoW-1:0] quo;
    logic [DenW-1:0]            den;
    logic [7:0]                 alpha;
    logic                       low;
  } aohl_div_t;

endpackage
`default_nettype wire

// ----- rtl/core/aohl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aohl_front
// Four-stage numerator / denominator datapath ahead of the divider.
// ----------------------------------------------------------------------------
module aohl_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [8:0]          weight_i,   // effective weight, 0..256
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire aohl_pkg::aohl_in_t  data_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output aohl_pkg::aohl_div_t      data_o
);

  localparam int NC = aohl_pkg::NumCh;
  localparam int NW = aohl_pkg::NumW;
  localparam int DW = aohl_pkg::DenW;

  logic [3:0] vld_q;
  logic [3:0] rdy;

  assign rdy[3]  = !vld_q[3] || ready_i;
  assign rdy[2]  = !vld_q[2] || rdy[3];
  assign rdy[1]  = !vld_q[1] || rdy[2];
  assign rdy[0]  = !vld_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
    end
  end

  // ---- stage 1: byte products, alpha sum, hard light numerator
  logic [7:0] bc [NC];
  logic [7:0] fc [NC];
  assign bc[0] = data_i.bg_blue;
  assign bc[1] = data_i.bg_green;
  assign bc[2] = data_i.bg_red;
  assign fc[0] = data_i.fg_blue;
  assign fc[1] = data_i.fg_green;
  assign fc[2] = data_i.fg_red;

  logic [15:0] pf_d [NC], pf_q [NC];
  logic [15:0] pb_d [NC], pb_q [NC];
  logic [15:0] hn_d [NC], hn_q [NC];
  logic [15:0] a1_d, a1_q;
  logic [7:0]  nfa_d, nfa_q;

  always_comb begin
    nfa_d = 8'd255 - data_i.fg_alpha;
    a1_d  = 16'(data_i.fg_alpha) * 16'd255 + 16'(data_i.bg_alpha) * 16'(nfa_d);
    for (int c = 0; c < NC; c++) begin
      pf_d[c] = 16'(fc[c]) * 16'(data_i.fg_alpha);
      pb_d[c] = 16'(bc[c]) * 16'(data_i.bg_alpha);
      if (fc[c][7]) begin
        // screen half
        hn_d[c] = 16'd65025 - ((16'(8'd255 - bc[c]) * 16'(8'd255 - fc[c])) << 1);
      end else begin
        hn_d[c] = (16'(bc[c]) * 16'(fc[c])) << 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pf_q  <= pf_d;
      pb_q  <= pb_d;
      hn_q  <= hn_d;
      a1_q  <= a1_d;
      nfa_q <= nfa_d;
    end
  end

  // ---- stage 2: colour numerators, weighted hard light, denominator
  logic [23:0]   n_d [NC], n_q [NC];
  logic [24:0]   hw_d [NC], hw_q [NC];
  logic [DW-1:0] den2_q;
  logic [15:0]   a2_q;
  logic [7:0]    alpha2_q;
  logic          low2_q;
  logic [15:0]   asum;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      n_d[c]  = 24'(pf_q[c]) * 24'd255 + 24'(pb_q[c]) * 24'(nfa_q);
      hw_d[c] = 25'(hn_q[c]) * 25'(weight_i);
    end
    // a / 255, exact over 0..65025
    asum = a1_q + (a1_q >> 8) + 16'd1;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      n_q      <= n_d;
      hw_q     <= hw_d;
      den2_q   <= (DW'(a1_q) << 16) - (DW'(a1_q) << 8);
      a2_q     <= a1_q;
      alpha2_q <= asum[15:8];
      low2_q   <= a1_q < aohl_pkg::AlphaFloor;
    end
  end

  // ---- stage 3: hard light term times alpha sum, colour term times 255
  logic [NW-1:0] t1_q [NC];
  logic [31:0]   n255_q [NC];
  logic [DW-1:0] den3_q;
  logic [7:0]    alpha3_q;
  logic          low3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int c = 0; c < NC; c++) begin
        t1_q[c]   <= NW'(hw_q[c]) * NW'(a2_q);
        n255_q[c] <= (32'(n_q[c]) << 8) - 32'(n_q[c]);
      end
      den3_q   <= den2_q;
      alpha3_q <= alpha2_q;
      low3_q   <= low2_q;
    end
  end

  // ---- stage 4: full numerator
  logic [8:0] wi;
  assign wi = aohl_pkg::WeightFull - weight_i;

  aohl_pkg::aohl_div_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int c = 0; c < NC; c++) begin
        out_q.rem[c] <= t1_q[c] + NW'(n255_q[c]) * NW'(wi);
        out_q.quo[c] <= '0;
      end
      out_q.den   <= den3_q;
      out_q.alpha <= alpha3_q;
      out_q.low   <= low3_q;
    end
  end

  assign data_o = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/aohl_div_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aohl_div_stage
// One restoring-division step: resolves quotient bit Bit for all channels.
// ----------------------------------------------------------------------------
module aohl_div_stage #(
  parameter int Bit = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire aohl_pkg::aohl_div_t  data_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output aohl_pkg::aohl_div_t       data_o
);

  localparam int NW = aohl_pkg::NumW;

  logic                vld_q;
  aohl_pkg::aohl_div_t data_d, data_q;
  logic [NW-1:0]       dsh;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;
  assign dsh     = NW'(data_i.den) << Bit;

  always_comb begin
    data_d = data_i;
    for (int c = 0; c < aohl_pkg::NumCh; c++) begin
      if (data_i.rem[c] >= dsh) begin
        data_d.rem[c]      = data_i.rem[c] - dsh;
        data_d.quo[c][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) data_q <= data_d;
  end

endmodule
`default_nettype wire

// ----- rtl/core/alpha_over_hard_light_blend_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_over_hard_light_blend_core
// Porter-Duff over composite of two BGRA pixels with optional hard light mix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one background
//   and one foreground pixel per request. Output channel out_valid_o /
//   out_stall_i / out_data_o returns one composited pixel per request, in
//   order. A request moves when valid is high and stall is low.
//   Throughput is one pixel per clock while the output is not stalled.
//   Four stages build the numerator and denominator, then eight stages
//   each resolve one quotient bit of the per-channel divide.
//   Every stage holds its own valid bit; a stage loads whenever it is empty
//   or the stage after it moves, so bubbles close up and new requests are
//   still taken while a finished pixel waits at a stalled output.
//   The user must write configuration (cfg_we_i, cfg_idx_i, cfg_data_i)
//   only while the pipe is empty; the block does not enforce this. Reset
//   empties the pipe, clears hard light enable and sets the weight to 256.
// ----------------------------------------------------------------------------
module alpha_over_hard_light_blend_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_idx_i,
  input  wire logic [8:0]          cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire aohl_pkg::aohl_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output aohl_pkg::aohl_out_t      out_data_o
);

  localparam int NStage = aohl_pkg::QuoW;

  logic       hl_en_q;
  logic [8:0] hl_weight_q;
  logic [8:0] weight;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_en_q     <= 1'b0;
      hl_weight_q <= aohl_pkg::WeightFull;
    end else if (cfg_we_i) begin
      unique case (aohl_pkg::cfg_idx_e'(cfg_idx_i))
        aohl_pkg::CfgHlEnable: hl_en_q     <= cfg_data_i[0];
        aohl_pkg::CfgHlWeight: hl_weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Disabled is the same quotient as weight zero
  always_comb begin
    if (!hl_en_q) begin
      weight = '0;
    end else if (hl_weight_q > aohl_pkg::WeightFull) begin
      weight = aohl_pkg::WeightFull;
    end else begin
      weight = hl_weight_q;
    end
  end

  logic                vld [NStage+1];
  logic                rdy [NStage+1];
  aohl_pkg::aohl_div_t dat [NStage+1];
  logic                front_ready;

  aohl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .weight_i (weight),
    .valid_i  (in_valid_i),
    .ready_o  (front_ready),
    .data_i   (in_data_i),
    .valid_o  (vld[0]),
    .ready_i  (rdy[0]),
    .data_o   (dat[0])
  );

  for (genvar j = 0; j < NStage; j++) begin : g_div
    aohl_div_stage #(
      .Bit (NStage - 1 - j)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[j]),
      .ready_o (rdy[j]),
      .data_i  (dat[j]),
      .valid_o (vld[j+1]),
      .ready_i (rdy[j+1]),
      .data_o  (dat[j+1])
    );
  end

  assign rdy[NStage] = !out_stall_i;
  assign in_stall_o  = !front_ready;
  assign out_valid_o = vld[NStage];

  always_comb begin
    if (dat[NStage].low) begin
      out_data_o = '0;
    end else begin
      out_data_o.out_blue  = dat[NStage].quo[0];
      out_data_o.out_green = dat[NStage].quo[1];
      out_data_o.out_red   = dat[NStage].quo[2];
      out_data_o.out_alpha = dat[NStage].alpha;
    end
  end

endmodule
`default_nettype wire
